@@ rtl/cddo_pkg.sv @@
package cddo_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_IN_W = 14;
    // Working year has room for the carries of the longest forward walk.
    localparam int YEAR_W    = 15;
    localparam int COUNT_W   = 16;
    localparam int DOY_W     = 9;
    localparam int LEN_W     = 5;
    // Signed running day: covers day + count and day - count.
    localparam int D_W       = 18;
    localparam int PC_W      = 4;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [YEAR_W-1:0] CYCLE_YEARS = 15'd400;
    localparam logic [YEAR_W-1:0] CYCLE_LAST  = 15'd399;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SUB400,
        OP_SET_BAD,
        OP_SET_RANGE,
        OP_ADD_STEP,
        OP_SUB_STEP,
        OP_DOY_INIT,
        OP_DOY_ADD,
        OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_START,
        C_REM_GE400,
        C_INVALID,
        C_ACT_ADD,
        C_ACT_SUB,
        C_D_GT_LEN,
        C_YEAR_GT_MAX,
        C_SUB_MORE,
        C_D_POS,
        C_M_LT_MONTH
    } cond_t;

    typedef logic [PC_W-1:0] upc_t;

    typedef struct packed {
        op_t  op;
        logic exec;
    } ctrl_t;

    typedef struct packed {
        logic rem_ge400;
        logic invalid;
        logic act_add;
        logic act_sub;
        logic d_gt_len;
        logic year_gt_max;
        logic sub_more;
        logic d_pos;
        logic m_lt_month;
    } flags_t;

    // Leap test on the year taken modulo 400.
    function automatic logic is_leap(input logic [YEAR_W-1:0] r);
        is_leap = (r[1:0] == 2'b00) && (r != 15'd100) && (r != 15'd200) && (r != 15'd300);
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = 5'd30;
            MONTH_FEB: month_len = leap ? 5'd29 : 5'd28;
            default:   month_len = 5'd31;
        endcase
    endfunction

endpackage

@@ rtl/cddo_seq.sv @@
module cddo_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cddo_pkg::flags_t flags,
    output cddo_pkg::ctrl_t  ctrl,
    output logic            busy
);
    import cddo_pkg::*;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
        logic  hold;
    } uword_t;

    localparam upc_t PC_IDLE     = 4'd0;
    localparam upc_t PC_REDUCE   = 4'd1;
    localparam upc_t PC_CHECK    = 4'd2;
    localparam upc_t PC_DISP_SUB = 4'd3;
    localparam upc_t PC_DISP_ADD = 4'd4;
    localparam upc_t PC_PASS     = 4'd5;
    localparam upc_t PC_ADD_LOOP = 4'd6;
    localparam upc_t PC_ADD_CHK  = 4'd7;
    localparam upc_t PC_ADD_END  = 4'd8;
    localparam upc_t PC_SUB_LOOP = 4'd9;
    localparam upc_t PC_SUB_CHK  = 4'd10;
    localparam upc_t PC_SUB_ERR  = 4'd11;
    localparam upc_t PC_DOY_INIT = 4'd12;
    localparam upc_t PC_DOY_LOOP = 4'd13;
    localparam upc_t PC_OUT      = 4'd14;

    // Control store: run op and jump when the condition holds, else hold or fall through.
    function automatic uword_t rom(input upc_t pc);
        case (pc)
            PC_IDLE:     rom = '{OP_LOAD,      C_START,       PC_REDUCE,   1'b1};
            PC_REDUCE:   rom = '{OP_SUB400,    C_REM_GE400,   PC_REDUCE,   1'b0};
            PC_CHECK:    rom = '{OP_SET_BAD,   C_INVALID,     PC_OUT,      1'b0};
            PC_DISP_SUB: rom = '{OP_NOP,       C_ACT_SUB,     PC_SUB_LOOP, 1'b0};
            PC_DISP_ADD: rom = '{OP_NOP,       C_ACT_ADD,     PC_ADD_LOOP, 1'b0};
            PC_PASS:     rom = '{OP_NOP,       C_ALWAYS,      PC_DOY_INIT, 1'b0};
            PC_ADD_LOOP: rom = '{OP_ADD_STEP,  C_D_GT_LEN,    PC_ADD_LOOP, 1'b0};
            PC_ADD_CHK:  rom = '{OP_SET_RANGE, C_YEAR_GT_MAX, PC_OUT,      1'b0};
            PC_ADD_END:  rom = '{OP_NOP,       C_ALWAYS,      PC_DOY_INIT, 1'b0};
            PC_SUB_LOOP: rom = '{OP_SUB_STEP,  C_SUB_MORE,    PC_SUB_LOOP, 1'b0};
            PC_SUB_CHK:  rom = '{OP_NOP,       C_D_POS,       PC_DOY_INIT, 1'b0};
            PC_SUB_ERR:  rom = '{OP_SET_RANGE, C_ALWAYS,      PC_OUT,      1'b0};
            PC_DOY_INIT: rom = '{OP_DOY_INIT,  C_ALWAYS,      PC_DOY_LOOP, 1'b0};
            PC_DOY_LOOP: rom = '{OP_DOY_ADD,   C_M_LT_MONTH,  PC_DOY_LOOP, 1'b0};
            PC_OUT:      rom = '{OP_FINISH,    C_ALWAYS,      PC_IDLE,     1'b0};
            default:     rom = '{OP_NOP,       C_ALWAYS,      PC_IDLE,     1'b0};
        endcase
    endfunction

    upc_t   pc_reg;
    upc_t   pc_next;
    uword_t word;
    logic   cond_true;

    assign word = rom(pc_reg);

    always_comb
    begin
        case (word.cond)
            C_ALWAYS:      cond_true = 1'b1;
            C_START:       cond_true = start;
            C_REM_GE400:   cond_true = flags.rem_ge400;
            C_INVALID:     cond_true = flags.invalid;
            C_ACT_ADD:     cond_true = flags.act_add;
            C_ACT_SUB:     cond_true = flags.act_sub;
            C_D_GT_LEN:    cond_true = flags.d_gt_len;
            C_YEAR_GT_MAX: cond_true = flags.year_gt_max;
            C_SUB_MORE:    cond_true = flags.sub_more;
            C_D_POS:       cond_true = flags.d_pos;
            C_M_LT_MONTH:  cond_true = flags.m_lt_month;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_true)
            pc_next = word.target;
        else if (word.hold)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_IDLE;
        else
            pc_reg <= pc_next;
    end

    assign ctrl.op   = word.op;
    assign ctrl.exec = cond_true;
    assign busy      = (pc_reg != PC_IDLE);

endmodule

@@ rtl/cddo_dp.sv @@
module cddo_dp #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cddo_pkg::ctrl_t                    ctrl,
    input  logic [1:0]                         action,
    input  logic [cddo_pkg::DAY_W-1:0]         in_day,
    input  logic [cddo_pkg::MONTH_W-1:0]       in_month,
    input  logic [cddo_pkg::YEAR_IN_W-1:0]     in_year,
    input  logic [cddo_pkg::COUNT_W-1:0]       day_count,
    output cddo_pkg::flags_t                   flags,
    output logic                               done,
    output logic [cddo_pkg::DAY_W-1:0]         out_day,
    output logic [cddo_pkg::MONTH_W-1:0]       out_month,
    output logic [cddo_pkg::YEAR_IN_W-1:0]     out_year,
    output logic [cddo_pkg::DOY_W-1:0]         day_of_year,
    output logic [1:0]                         status
);
    import cddo_pkg::*;

    localparam logic [16:0] YEAR_LIMIT = 17'(YEAR_MAX);

    logic [1:0]            act_reg;
    logic [DAY_W-1:0]      day_reg;
    logic signed [D_W-1:0] d_reg,     d_next;
    logic [MONTH_W-1:0]    month_reg, month_next;
    logic [YEAR_W-1:0]     year_reg,  year_next;
    logic [YEAR_W-1:0]     rem_reg,   rem_next;
    logic [MONTH_W-1:0]    m_reg,     m_next;
    logic [DOY_W-1:0]      doy_reg,   doy_next;
    logic [1:0]            st_reg,    st_next;
    logic                  done_reg;

    logic [DAY_W-1:0]      oday_reg;
    logic [MONTH_W-1:0]    omonth_reg;
    logic [YEAR_IN_W-1:0]  oyear_reg;
    logic [DOY_W-1:0]      odoy_reg;
    logic [1:0]            ost_reg;

    logic                  run;
    logic [MONTH_W-1:0]    prev_month;
    logic [MONTH_W-1:0]    len_month;
    logic [LEN_W-1:0]      len;
    logic signed [D_W-1:0] len_s;
    logic signed [D_W-1:0] day_s;
    logic signed [D_W-1:0] cnt_s;

    assign run        = ctrl.exec;
    assign prev_month = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;

    // One month-length lookup, steered by the step being run.
    always_comb
    begin
        case (ctrl.op)
            OP_DOY_ADD:  len_month = m_reg;
            OP_SUB_STEP: len_month = prev_month;
            default:     len_month = month_reg;
        endcase
    end

    assign len   = month_len(len_month, is_leap(rem_reg));
    assign len_s = $signed({{(D_W-LEN_W){1'b0}}, len});
    assign day_s = $signed({{(D_W-DAY_W){1'b0}}, in_day});
    assign cnt_s = $signed({{(D_W-COUNT_W){1'b0}}, day_count});

    assign flags.rem_ge400   = (rem_reg >= CYCLE_YEARS);
    assign flags.invalid     = (year_reg == '0) || ({2'b00, year_reg} > YEAR_LIMIT) ||
                               (month_reg == '0) || (month_reg > MONTH_DEC) ||
                               (day_reg == '0) || (day_reg > len);
    assign flags.act_add     = (act_reg == ACT_ADD);
    assign flags.act_sub     = (act_reg == ACT_SUB);
    assign flags.d_gt_len    = (d_reg > len_s);
    assign flags.year_gt_max = ({2'b00, year_reg} > YEAR_LIMIT);
    assign flags.sub_more    = (d_reg <= 0) && !((month_reg == MONTH_JAN) && (year_reg == 15'd1));
    assign flags.d_pos       = (d_reg > 0);
    assign flags.m_lt_month  = (m_reg < month_reg);

    always_comb
    begin
        d_next     = d_reg;
        month_next = month_reg;
        year_next  = year_reg;
        rem_next   = rem_reg;
        m_next     = m_reg;
        doy_next   = doy_reg;
        st_next    = st_reg;
        if (run)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    if (action == ACT_ADD)
                        d_next = day_s + cnt_s;
                    else if (action == ACT_SUB)
                        d_next = day_s - cnt_s;
                    else
                        d_next = day_s;
                    month_next = in_month;
                    year_next  = {1'b0, in_year};
                    rem_next   = {1'b0, in_year};
                    st_next    = ST_OK;
                end
                OP_SUB400:    rem_next = rem_reg - CYCLE_YEARS;
                OP_SET_BAD:   st_next  = ST_BAD_DATE;
                OP_SET_RANGE: st_next  = ST_RANGE;
                OP_ADD_STEP:
                begin
                    d_next = d_reg - len_s;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + 15'd1;
                        rem_next   = (rem_reg == CYCLE_LAST) ? '0 : rem_reg + 15'd1;
                    end
                    else
                        month_next = month_reg + 4'd1;
                end
                OP_SUB_STEP:
                begin
                    // December is 31 days either way, so the leap of the
                    // year being left does not matter here.
                    d_next     = d_reg + len_s;
                    month_next = prev_month;
                    if (month_reg == MONTH_JAN)
                    begin
                        year_next = year_reg - 15'd1;
                        rem_next  = (rem_reg == '0) ? CYCLE_LAST : rem_reg - 15'd1;
                    end
                end
                OP_DOY_INIT:
                begin
                    doy_next = d_reg[DOY_W-1:0];
                    m_next   = MONTH_JAN;
                end
                OP_DOY_ADD:
                begin
                    doy_next = doy_reg + {{(DOY_W-LEN_W){1'b0}}, len};
                    m_next   = m_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (run && (ctrl.op == OP_LOAD))
        begin
            act_reg <= action;
            day_reg <= in_day;
        end
        d_reg     <= d_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        rem_reg   <= rem_next;
        m_reg     <= m_next;
        doy_reg   <= doy_next;
        st_reg    <= st_next;
        if (run && (ctrl.op == OP_FINISH))
        begin
            ost_reg <= st_reg;
            if (st_reg == ST_OK)
            begin
                oday_reg   <= d_reg[DAY_W-1:0];
                omonth_reg <= month_reg;
                oyear_reg  <= year_reg[YEAR_IN_W-1:0];
                odoy_reg   <= doy_reg;
            end
            else
            begin
                oday_reg   <= '0;
                omonth_reg <= '0;
                oyear_reg  <= '0;
                odoy_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= run && (ctrl.op == OP_FINISH);
    end

    assign done        = done_reg;
    assign out_day     = oday_reg;
    assign out_month   = omonth_reg;
    assign out_year    = oyear_reg;
    assign day_of_year = odoy_reg;
    assign status      = ost_reg;

endmodule

@@ rtl/calendar_date_day_offset.sv @@
// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------------------------
// command   start high, busy low   action, in_day, in_month, in_year, day_count
// result    done (one-cycle pulse) out_day, out_month, out_year, day_of_year, status
//
// One command at a time: busy is high from the cycle after the transfer to the cycle
// before the done pulse, while the year is reduced modulo 400, the months crossed are
// walked and the months before the result month are summed; an invalid date ends the
// run after the check.
// Reset clears the step counter and the result strobe; data registers are not reset.
// The receiver cannot stall; a new command may transfer in the done cycle.
module calendar_date_day_offset #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic [cddo_pkg::DAY_W-1:0]         in_day,
    input  logic [cddo_pkg::MONTH_W-1:0]       in_month,
    input  logic [cddo_pkg::YEAR_IN_W-1:0]     in_year,
    input  logic [cddo_pkg::COUNT_W-1:0]       day_count,
    output logic                               done,
    output logic [cddo_pkg::DAY_W-1:0]         out_day,
    output logic [cddo_pkg::MONTH_W-1:0]       out_month,
    output logic [cddo_pkg::YEAR_IN_W-1:0]     out_year,
    output logic [cddo_pkg::DOY_W-1:0]         day_of_year,
    output logic [1:0]                         status
);
    import cddo_pkg::*;

    // Control word from the sequencer and condition flags back from the datapath.
    ctrl_t  ctrl;
    flags_t flags;

    // Step counter and control store: wait for a command, reduce the year
    // modulo 400, check the date, walk months forward or back for add or
    // subtract, then sum the month lengths for the ordinal day and publish.
    cddo_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Plain datapath: running day, month, year, year modulo 400, ordinal day,
    // status and the result registers.
    cddo_dp #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .action      (action),
        .in_day      (in_day),
        .in_month    (in_month),
        .in_year     (in_year),
        .day_count   (day_count),
        .flags       (flags),
        .done        (done),
        .out_day     (out_day),
        .out_month   (out_month),
        .out_year    (out_year),
        .day_of_year (day_of_year),
        .status      (status)
    );

    // A transfer always starts the program.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not start the sequencer");

    // A result follows the end of a program run.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding run");

    // Error results carry a zero date.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |->
            (out_day == '0) && (out_month == '0) && (out_year == '0) && (day_of_year == '0))
        else $error("error result carries a nonzero date");

    // Good results have a month from 1 to 12, a nonzero day and a nonzero ordinal day.
    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_OK)) |->
            (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day != '0) &&
            (day_of_year != '0))
        else $error("good result is not a valid date");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Date offset unit check: add, subtract, ordinal-day and spare-code commands go
// through the start/busy handshake. Each transfer is predicted in the bench,
// and every done pulse is compared against the oldest outstanding prediction.
module tb_top;

    import cddo_pkg::*;

    localparam int unsigned YEAR_MAX    = 9999;
    localparam int          NUM_RANDOM  = 250;
    // Keep the last commands free of start gaps.
    localparam int          TAIL_ITEMS  = 40;
    localparam int          DRAIN_WAIT  = 20;

    // Action codes that the package leaves unnamed.
    localparam logic [1:0] ACT_DOY   = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_IN_W-1:0] year;
        logic [COUNT_W-1:0]   count;
    } date_cmd_t;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_IN_W-1:0] year;
        logic [DOY_W-1:0]     doy;
        logic [1:0]           status;
    } date_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           action;
    logic [DAY_W-1:0]     in_day;
    logic [MONTH_W-1:0]   in_month;
    logic [YEAR_IN_W-1:0] in_year;
    logic [COUNT_W-1:0]   day_count;
    logic                 done;
    logic [DAY_W-1:0]     out_day;
    logic [MONTH_W-1:0]   out_month;
    logic [YEAR_IN_W-1:0] out_year;
    logic [DOY_W-1:0]     day_of_year;
    logic [1:0]           status;

    date_cmd_t pending_cmds[$];
    date_res_t expected_dates[$];
    int        gap_left;
    bit        mismatch_seen;

    calendar_date_day_offset #(
        .YEAR_MAX(YEAR_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .in_day(in_day),
        .in_month(in_month),
        .in_year(in_year),
        .day_count(day_count),
        .done(done),
        .out_day(out_day),
        .out_month(out_month),
        .out_year(out_year),
        .day_of_year(day_of_year),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar arithmetic for the prediction
    // ------------------------------------------------------------------
    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Walk the calendar one month at a time, exactly as the unit does, then
    // count the ordinal day of whatever date the walk lands on.
    function automatic date_res_t offset_date(date_cmd_t c);
        date_res_t   r;
        int unsigned mon;
        int unsigned yr;
        int unsigned dd;
        int unsigned doy;
        int          ds;
        logic [1:0]  st;
        r   = '0;
        mon = 32'(c.month);
        yr  = 32'(c.year);
        dd  = 32'(c.day);
        st  = ST_OK;
        if (yr == 0 || yr > YEAR_MAX || mon == 0 || mon > 12 || dd == 0 ||
            dd > month_days(mon, yr))
        begin
            st = ST_BAD_DATE;
        end
        else if (c.action == ACT_ADD)
        begin
            dd = dd + 32'(c.count);
            while (dd > month_days(mon, yr))
            begin
                dd -= month_days(mon, yr);
                mon++;
                if (mon > 12)
                begin
                    mon = 1;
                    yr++;
                end
            end
            if (yr > YEAR_MAX)
                st = ST_RANGE;
        end
        else if (c.action == ACT_SUB)
        begin
            ds = int'(dd) - int'(c.count);
            while (ds <= 0)
            begin
                mon--;
                if (mon < 1)
                begin
                    mon = 12;
                    // Stepping back past January of year 1 is out of range.
                    if (yr == 1)
                    begin
                        st = ST_RANGE;
                        break;
                    end
                    yr--;
                end
                ds += month_days(mon, yr);
            end
            if (st == ST_OK)
                dd = ds;
        end
        r.status = st;
        if (st == ST_OK)
        begin
            doy = dd;
            for (int unsigned m = 1; m < mon; m++)
                doy += month_days(m, yr);
            r.day   = 5'(dd);
            r.month = 4'(mon);
            r.year  = 14'(yr);
            r.doy   = 9'(doy);
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    task automatic queue_cmd(logic [1:0] act, int unsigned d, int unsigned m,
                             int unsigned y, int unsigned n);
        date_cmd_t c;
        c.action = act;
        c.day    = 5'(d);
        c.month  = 4'(m);
        c.year   = 14'(y);
        c.count  = 16'(n);
        pending_cmds.push_back(c);
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge only. Hold the front command
    // on the ports until a rising edge sees start high and busy low; drop
    // start now and then for a short burst so that gaps land on every phase
    // of a command, including the done cycle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                begin
                    // This cycle is the first of a burst of one to three.
                    start    <= 1'b0;
                    gap_left = $urandom_range(0, 2);
                end
                else
                begin
                    start     <= 1'b1;
                    action    <= pending_cmds[0].action;
                    in_day    <= pending_cmds[0].day;
                    in_month  <= pending_cmds[0].month;
                    in_year   <= pending_cmds[0].year;
                    day_count <= pending_cmds[0].count;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge. Check the done pulse first, since
    // a new command may transfer in the very cycle that the old result shows.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        date_res_t want;
        date_cmd_t seen;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t ns: unexpected done, expected none, got %0d/%0d/%0d status %0d",
                             $time, out_day, out_month, out_year, status);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("out_day", 32'(want.day), 32'(out_day));
                    check_field("out_month", 32'(want.month), 32'(out_month));
                    check_field("out_year", 32'(want.year), 32'(out_year));
                    check_field("day_of_year", 32'(want.doy), 32'(day_of_year));
                    check_field("status", 32'(want.status), 32'(status));
                end
            end
            // Predict from what is actually on the ports at the transfer.
            if (start && !busy)
            begin
                seen.action = action;
                seen.day    = in_day;
                seen.month  = in_month;
                seen.year   = in_year;
                seen.count  = day_count;
                expected_dates.push_back(offset_date(seen));
                void'(pending_cmds.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        date_cmd_t   c;
        int unsigned pick;
        int unsigned yr;
        int unsigned mo;

        rst_n         = 1'b0;
        start         = 1'b0;
        action        = '0;
        in_day        = '0;
        in_month      = '0;
        in_year       = '0;
        day_count     = '0;
        gap_left      = 0;
        mismatch_seen = 1'b0;

        // Directed part: zero count, year edges, leap rules, bad dates,
        // unused action code, full-size counts both ways.
        queue_cmd(ACT_ADD,   15,  6, 2023,     0);
        queue_cmd(ACT_ADD,   31, 12, 9999,     1);
        queue_cmd(ACT_SUB,    1,  1,    1,     1);
        queue_cmd(ACT_SUB,    1,  1,    1,     0);
        queue_cmd(ACT_ADD,    1,  1,    1, 65535);
        queue_cmd(ACT_SUB,   31, 12, 9999, 65535);
        queue_cmd(ACT_ADD,   28,  2, 2000,     1);
        queue_cmd(ACT_ADD,   28,  2, 1900,     1);
        queue_cmd(ACT_SUB,    1,  3, 2000,     1);
        queue_cmd(ACT_SUB,    1,  3, 2100,     1);
        queue_cmd(ACT_DOY,   31, 12, 2000,    77);
        queue_cmd(ACT_SPARE, 29,  2, 2024, 65535);
        queue_cmd(ACT_ADD,    0,  5, 2020,     3);
        queue_cmd(ACT_ADD,   31,  4, 2020,     3);
        queue_cmd(ACT_SUB,   29,  2, 1900,     3);
        queue_cmd(ACT_ADD,    1,  0, 2020,     3);
        queue_cmd(ACT_SUB,    1, 15, 2020,     3);
        queue_cmd(ACT_ADD,    1,  1,    0,     3);
        queue_cmd(ACT_ADD,    1,  1, 16383,    3);
        queue_cmd(ACT_DOY,   31,  1, YEAR_MAX + 1, 0);
        queue_cmd(ACT_ADD,    1, 12, 9999,    30);
        queue_cmd(ACT_ADD,    1, 12, 9999,    31);
        queue_cmd(ACT_SUB,   31, 12,  100, 65535);
        queue_cmd(ACT_ADD,   31,  1, 2023,    29);

        // Random part: mostly valid dates with years near the edges and on
        // centuries, some raw bit patterns; counts mostly short so that the
        // month walk stays fast, with a few near the top of the range.
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            c.action = (pick < 40) ? ACT_ADD : (pick < 80) ? ACT_SUB :
                       (pick < 90) ? ACT_DOY : ACT_SPARE;
            if ($urandom_range(0, 99) < 12)
            begin
                c.day   = 5'($urandom_range(0, 31));
                c.month = 4'($urandom_range(0, 15));
                c.year  = 14'($urandom_range(0, 16383));
            end
            else
            begin
                pick = $urandom_range(0, 9);
                yr = (pick < 2) ? $urandom_range(1, 4) :
                     (pick < 4) ? $urandom_range(YEAR_MAX - 4, YEAR_MAX) :
                     (pick < 5) ? 100 * $urandom_range(1, YEAR_MAX / 100) :
                     $urandom_range(1, YEAR_MAX);
                mo = $urandom_range(1, 12);
                c.year  = 14'(yr);
                c.month = 4'(mo);
                // Favor the last day of the month, where the carries start.
                c.day   = 5'(($urandom_range(0, 3) == 0) ? month_days(mo, yr) :
                             $urandom_range(1, month_days(mo, yr)));
            end
            pick = $urandom_range(0, 19);
            c.count = 16'((pick < 2)  ? $urandom_range(0, 2) :
                          (pick < 12) ? $urandom_range(0, 400) :
                          (pick < 18) ? $urandom_range(0, 6000) :
                          $urandom_range(40000, 65535));
            pending_cmds.push_back(c);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every command to transfer and every result to come back,
        // then watch a little longer for a stray done pulse.
        while (pending_cmds.size() != 0 || expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (!mismatch_seen)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop, a few times over the slowest legal run.
    initial
    begin
        #60000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cddo_pkg.sv
rtl/cddo_seq.sv
rtl/cddo_dp.sv
rtl/calendar_date_day_offset.sv
tb/tb_top.sv
